// ===== hw/rtl/oflt_pkg.sv =====
// Package with shared constants, codes and types of the open-file LRU tracker.
`default_nettype none
package oflt_pkg;
    localparam int SlotsDef = 16;
    localparam int OwnerBitsDef = 8;
    localparam int MaxResults = 16;

    typedef enum logic [2:0] {
        ACT_REGISTER = 3'd0,
        ACT_UNREGISTER = 3'd1,
        ACT_USE = 3'd2,
        ACT_CLOSE = 3'd3,
        ACT_RELEASE_OWNER = 3'd4,
        ACT_FLUSH = 3'd5
    } t_action;

    localparam logic [2:0] KIND_DONE = 3'd0;
    localparam logic [2:0] KIND_ALLOC = 3'd1;
    localparam logic [2:0] KIND_RELEASE = 3'd2;
    localparam logic [2:0] KIND_FLUSH = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [1:0] REG_MAX_OPEN = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_SCAN,
        ST_EMIT,
        ST_PUSH,
        ST_FINISH
    } t_state;

    // Per-cell command broadcast by the controller to every cell.
    typedef struct packed {
        logic set_valid;
        logic clr_valid;
        logic set_dirty;
        logic clr_dirty;
        logic dequeue;
        logic push;
    } t_cell_cmd;
endpackage
`default_nettype wire

// ===== hw/rtl/oflt_if.sv =====
// Valid/ready channel interface used for the request and result streams.
`default_nettype none
interface oflt_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/oflt_cell.sv =====
// One slot cell: valid, owner, dirty, queued and recency rank of one file slot.
`default_nettype none
module oflt_cell
    import oflt_pkg::*;
#(
    parameter int OWNER_BITS = OwnerBitsDef,
    parameter int RANK_BITS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_sel,
    input  wire t_cell_cmd             i_cmd,
    input  wire logic [OWNER_BITS-1:0] i_owner,
    // Rank of the entry leaving the queue, broadcast down the row.
    input  wire logic                  i_deq_any,
    input  wire logic [RANK_BITS-1:0]  i_deq_rank,
    input  wire logic                  i_push_any,
    output logic                       o_valid,
    output logic                       o_dirty,
    output logic                       o_queued,
    output logic                       o_owner_hit,
    output logic [RANK_BITS-1:0]       o_rank
);
    logic                  r_valid, r_dirty, r_queued;
    logic [OWNER_BITS-1:0] r_owner;
    logic [RANK_BITS-1:0]  r_rank;
    logic [RANK_BITS-1:0]  n_rank;
    logic                  n_queued;

    // Rank update: close the gap left by a dequeue, then shift for a push.
    always_comb begin
        n_queued = r_queued;
        n_rank = r_rank;
        if (i_deq_any && r_queued && r_rank > i_deq_rank) begin
            n_rank = r_rank - RANK_BITS'(1);
        end
        if (i_sel && i_cmd.dequeue) begin
            n_queued = 1'b0;
        end
        if (i_push_any && n_queued) begin
            n_rank = n_rank + RANK_BITS'(1);
        end
        if (i_sel && i_cmd.push) begin
            n_queued = 1'b1;
            n_rank = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_queued <= 1'b0;
        end else begin
            r_queued <= n_queued;
            if (i_sel && i_cmd.set_valid) begin
                r_valid <= 1'b1;
            end else if (i_sel && i_cmd.clr_valid) begin
                r_valid <= 1'b0;
            end
            if (i_sel && i_cmd.clr_dirty) begin
                r_dirty <= 1'b0;
            end else if (i_sel && i_cmd.set_dirty) begin
                r_dirty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank <= n_rank;
        if (i_sel && i_cmd.set_valid) begin
            r_owner <= i_owner;
        end
    end

    assign o_valid = r_valid;
    assign o_dirty = r_dirty;
    assign o_queued = r_queued;
    assign o_rank = r_rank;
    assign o_owner_hit = r_valid && (r_owner == i_owner);
endmodule
`default_nettype wire

// ===== hw/rtl/open_file_lru_tracker.sv =====
// Top level of the open-file LRU tracker: controller, cell row and ports.
//
// One request is worked on at a time. After the accepting edge the request
// passes a decode state (ALLOC) and a row-update state (EMIT) in which its
// result is registered; register, unregister, close and unknown actions
// then return to idle for the next request, and use passes a push state
// to make the slot most-recent. Release_owner walks the row one slot a
// cycle and flush walks the queue one rank a cycle while the output is not
// stalled, each stopping early after its final result. A result that waits
// on a stalled output holds the controller for as long as the stall lasts.
// The max_open register is written at byte address 0 of the APB port.
`default_nettype none
module open_file_lru_tracker
    import oflt_pkg::*;
#(
    parameter int SLOTS = SlotsDef,
    parameter int OWNER_BITS = OwnerBitsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    oflt_if.sink             i_req,
    oflt_if.source           o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int SB = $clog2(SLOTS);
    localparam int CB = $clog2(SLOTS + 1);

    // Request payload: action, slot, owner, to_flush.
    logic [2:0] req_action;
    logic [3:0] req_slot;
    logic [7:0] req_owner;
    logic       req_to_flush;
    assign req_action = i_req.data[15:13];
    assign req_slot = i_req.data[12:9];
    assign req_owner = i_req.data[8:1];
    assign req_to_flush = i_req.data[0];

    // Configuration register.
    logic [4:0] r_max_open;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_OPEN) ? {27'd0, r_max_open} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_open <= 5'd16;
        end else if (psel && penable && pwrite && paddr == REG_MAX_OPEN) begin
            r_max_open <= pwdata[4:0];
        end
    end

    // Held request.
    logic [2:0]            r_act;
    logic [3:0]            r_slot_in;
    logic [OWNER_BITS-1:0] r_owner;
    logic                  r_flush_in;
    logic                  r_ok;

    // Controller state.
    t_state r_state, n_state;
    logic [CB-1:0] r_cnt, n_cnt;     // scan position
    logic [4:0]    r_nres;           // results given for this request
    logic [CB-1:0] r_qcount;
    logic [2:0]    r_kind;
    logic [3:0]    r_rslot;
    logic          r_last;
    logic          r_out_valid;

    // Cell row.
    logic [SLOTS-1:0] c_valid, c_dirty, c_queued, c_hit, c_sel;
    logic [SB-1:0]    c_rank [SLOTS];
    t_cell_cmd        cmd;
    logic             deq_any, push_any;
    logic [SB-1:0]    deq_rank;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        oflt_cell #(.OWNER_BITS(OWNER_BITS), .RANK_BITS(SB)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sel(c_sel[g]), .i_cmd(cmd),
            .i_owner(r_owner), .i_deq_any(deq_any), .i_deq_rank(deq_rank),
            .i_push_any(push_any), .o_valid(c_valid[g]), .o_dirty(c_dirty[g]),
            .o_queued(c_queued[g]), .o_owner_hit(c_hit[g]), .o_rank(c_rank[g])
        );
    end

    // Lowest free slot.
    logic [SB-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!c_valid[i]) begin
                free_idx = SB'(i);
                free_any = 1'b1;
            end
        end
    end

    // Slot whose rank matches a target rank (one-hot over the row).
    logic [SB-1:0] tgt_rank, rank_idx;
    logic          rank_any;
    always_comb begin
        rank_idx = '0;
        rank_any = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (c_queued[i] && c_rank[i] == tgt_rank) begin
                rank_idx = SB'(i);
                rank_any = 1'b1;
            end
        end
    end

    // Matches still ahead of the scan position, so the final result is known.
    logic [SLOTS-1:0] more_hit, more_dirty;
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            more_hit[i] = c_hit[i] && (i > int'(r_cnt));
            more_dirty[i] = c_queued[i] && c_dirty[i] && (c_rank[i] < tgt_rank);
        end
    end

    logic [4:0]    limit;
    logic          out_free;
    logic [SB-1:0] slot_idx;
    logic          use_ok;
    logic          evict_hit;
    assign limit = (r_max_open == 5'd0) ? 5'd1 : r_max_open;
    assign out_free = !r_out_valid || o_res.ready;
    assign slot_idx = SB'(r_slot_in);
    assign use_ok = (r_act == ACT_USE) && r_ok && c_valid[slot_idx];
    assign evict_hit = !c_queued[slot_idx] && (32'(r_qcount) >= 32'(limit))
        && (r_qcount != '0) && rank_any;

    logic          emit;
    logic [2:0]    e_kind;
    logic [SB-1:0] e_slot;
    logic          e_last;
    logic [SB-1:0] sel_idx;
    logic          sel_en;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        unique case (r_state)
            ST_IDLE: if (i_req.valid) n_state = ST_ALLOC;
            ST_ALLOC: begin
                if (r_act == ACT_RELEASE_OWNER) begin
                    n_state = ST_SCAN;
                    n_cnt = '0;
                end else if (r_act == ACT_FLUSH) begin
                    n_state = ST_SCAN;
                    n_cnt = r_qcount;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN: if (out_free) begin
                if (r_act == ACT_RELEASE_OWNER) begin
                    if ((emit && e_last) || r_cnt == CB'(SLOTS - 1)) n_state = ST_FINISH;
                    else n_cnt = r_cnt + CB'(1);
                end else begin
                    if (r_cnt <= CB'(1) || (emit && e_last)) n_state = ST_FINISH;
                    else n_cnt = r_cnt - CB'(1);
                end
            end
            ST_EMIT: if (out_free) n_state = use_ok ? ST_PUSH : ST_IDLE;
            ST_PUSH: n_state = ST_IDLE;
            ST_FINISH: if (r_nres != '0 || out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Output logic: row commands and result generation.
    always_comb begin
        cmd = '0;
        sel_idx = slot_idx;
        sel_en = 1'b0;
        emit = 1'b0;
        e_kind = KIND_DONE;
        e_slot = '0;
        e_last = 1'b0;
        tgt_rank = SB'(r_qcount - CB'(1));
        unique case (r_state)
            ST_EMIT: if (out_free) begin
                emit = 1'b1;
                e_last = 1'b1;
                e_kind = KIND_ERROR;
                unique case (r_act)
                    ACT_REGISTER: if (free_any) begin
                        sel_idx = free_idx;
                        sel_en = 1'b1;
                        cmd.set_valid = 1'b1;
                        cmd.clr_dirty = 1'b1;
                        cmd.dequeue = 1'b1;
                        e_kind = KIND_ALLOC;
                        e_slot = free_idx;
                    end
                    ACT_UNREGISTER: if (r_ok && c_hit[slot_idx]) begin
                        sel_en = 1'b1;
                        cmd.clr_valid = 1'b1;
                        cmd.clr_dirty = 1'b1;
                        cmd.dequeue = 1'b1;
                        e_kind = KIND_DONE;
                    end
                    ACT_USE: if (use_ok) begin
                        // Leave the queue first; the push follows next cycle.
                        e_kind = KIND_DONE;
                        if (c_queued[slot_idx]) begin
                            sel_en = 1'b1;
                            cmd.dequeue = 1'b1;
                        end else if (evict_hit) begin
                            sel_idx = rank_idx;
                            sel_en = 1'b1;
                            cmd.dequeue = 1'b1;
                            e_kind = KIND_RELEASE;
                            e_slot = rank_idx;
                        end
                    end
                    ACT_CLOSE: begin
                        e_kind = KIND_DONE;
                        if (r_ok && c_queued[slot_idx]) begin
                            sel_en = 1'b1;
                            cmd.dequeue = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_PUSH: begin
                sel_en = 1'b1;
                cmd.push = 1'b1;
                cmd.set_dirty = r_flush_in;
            end
            ST_SCAN: begin
                tgt_rank = SB'(r_cnt - CB'(1));
                if (out_free) begin
                    if (r_act == ACT_RELEASE_OWNER) begin
                        sel_idx = SB'(r_cnt);
                        if (c_hit[sel_idx]) begin
                            emit = 1'b1;
                            e_kind = KIND_RELEASE;
                            e_slot = sel_idx;
                            sel_en = 1'b1;
                            cmd.dequeue = 1'b1;
                            e_last = !(|more_hit) || r_nres == 5'(MaxResults - 1);
                        end
                    end else if (r_cnt != '0 && rank_any && c_dirty[rank_idx]) begin
                        emit = 1'b1;
                        e_kind = KIND_FLUSH;
                        e_slot = rank_idx;
                        sel_idx = rank_idx;
                        sel_en = 1'b1;
                        cmd.clr_dirty = 1'b1;
                        e_last = !(|more_dirty) || r_nres == 5'(MaxResults - 1);
                    end
                end
            end
            ST_FINISH: begin
                // A scan with no results still answers done.
                if (r_nres == '0 && out_free) begin
                    emit = 1'b1;
                    e_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Row selection and the queue-wide rank updates.
    assign deq_any = sel_en && cmd.dequeue && c_queued[sel_idx];
    assign deq_rank = c_rank[sel_idx];
    assign push_any = sel_en && cmd.push;

    always_comb begin
        c_sel = '0;
        if (sel_en) c_sel[sel_idx] = 1'b1;
    end

    // Controller registers, queue count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_qcount <= '0;
            r_cnt <= '0;
            r_nres <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_qcount <= r_qcount - CB'(deq_any) + CB'(push_any);
            if (i_req.valid && i_req.ready) begin
                r_nres <= '0;
            end else if (emit) begin
                r_nres <= r_nres + 5'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Held request and result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_act <= req_action;
            r_slot_in <= req_slot;
            r_owner <= OWNER_BITS'(req_owner);
            r_flush_in <= req_to_flush;
            r_ok <= 32'(req_slot) < SLOTS;
        end
        if (emit) begin
            r_kind <= e_kind;
            r_rslot <= 4'(e_slot);
            r_last <= e_last;
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data = {r_kind, r_rslot, r_last};

`ifndef SYNTHESIS
    // The queue never holds more entries than there are slots.
    a_qcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount <= CB'(SLOTS)) else $error("queue count overflow");
    // A stalled result stays put until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(o_res.data)))
        else $error("result changed while stalled");
    // The queue count tracks the queued bits of the row.
    a_qsync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_qcount == CB'($countones(c_queued)))
        else $error("queue count out of step");
`endif
endmodule
`default_nettype wire

// ===== dv/tb_open_file_lru_tracker.sv =====
// Self-checking testbench for the open-file LRU tracker with dirty marks.
`timescale 1ns / 100ps
`default_nettype none
module tb_open_file_lru_tracker;
    import oflt_pkg::*;

    localparam int NSLOT = SlotsDef;
    localparam int IDLE_TAIL = 2 * NSLOT + 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [2:0] ACT_BAD_6 = 3'd6;
    localparam logic [2:0] ACT_BAD_7 = 3'd7;
    localparam logic [1:0] ADDR_MAX_OPEN = {REG_MAX_OPEN[1:0]};

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] slot;
        logic       last;
    } t_result;

    typedef struct {
        logic [2:0] action;
        logic [3:0] slot;
        logic [7:0] owner;
        logic       to_flush;
        bit         typed;
        logic [2:0] exp_kind;
        logic [3:0] exp_slot;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    oflt_if #(.W(16)) req_ch ();
    oflt_if #(.W(8)) res_ch ();

    open_file_lru_tracker DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch),
        .o_res(res_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Shadow copy of the tracker state.
    bit          sh_valid [NSLOT];
    logic [7:0]  sh_owner [NSLOT];
    bit          sh_dirty [NSLOT];
    bit          sh_queued [NSLOT];
    int          sh_rank [NSLOT];
    int          sh_count;
    logic [4:0]  sh_max_open;

    t_result pending_results [$];
    t_result step_results [$];
    int      errors;
    int      requests_sent;
    int      results_seen;
    int      idle_cycles;
    bit      calm;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, none while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void drop_from_queue(int s);
        if (!sh_queued[s]) return;
        for (int i = 0; i < NSLOT; i++) begin
            if (sh_queued[i] && sh_rank[i] > sh_rank[s]) sh_rank[i]--;
        end
        sh_queued[s] = 0;
        if (sh_count > 0) sh_count--;
    endfunction

    function automatic void make_most_recent(int s);
        for (int i = 0; i < NSLOT; i++) begin
            if (sh_queued[i]) sh_rank[i]++;
        end
        sh_queued[s] = 1;
        sh_rank[s] = 0;
        sh_count++;
    endfunction

    function automatic int slot_at_rank(int r);
        for (int i = 0; i < NSLOT; i++) begin
            if (sh_queued[i] && sh_rank[i] == r) return i;
        end
        return -1;
    endfunction

    function automatic void add_result(logic [2:0] kind, int s);
        t_result res;
        if (step_results.size() >= MaxResults) return;
        res.kind = kind;
        res.slot = 4'(s);
        res.last = 1'b0;
        step_results.push_back(res);
    endfunction

    // Works out the results of one request and updates the shadow state.
    function automatic void predict_tracker(logic [2:0] act, logic [3:0] s,
                                            logic [7:0] own, logic flush);
        int lim;
        int victim;
        int r;
        int i;
        lim = (sh_max_open == 0) ? 1 : int'(sh_max_open);
        step_results.delete();
        case (act)
            ACT_REGISTER: begin
                for (i = 0; i < NSLOT; i++) if (!sh_valid[i]) break;
                if (i < NSLOT) begin
                    sh_valid[i] = 1;
                    sh_owner[i] = own;
                    sh_dirty[i] = 0;
                    sh_queued[i] = 0;
                    add_result(KIND_ALLOC, i);
                end
            end
            ACT_UNREGISTER: begin
                if (sh_valid[s] && sh_owner[s] == own) begin
                    drop_from_queue(s);
                    sh_valid[s] = 0;
                    sh_dirty[s] = 0;
                    add_result(KIND_DONE, 0);
                end
            end
            ACT_USE: begin
                if (sh_valid[s]) begin
                    if (flush) sh_dirty[s] = 1;
                    if (sh_queued[s]) begin
                        drop_from_queue(s);
                    end else if (sh_count >= lim && sh_count > 0) begin
                        victim = slot_at_rank(sh_count - 1);
                        if (victim >= 0) begin
                            add_result(KIND_RELEASE, victim);
                            drop_from_queue(victim);
                        end
                    end
                    make_most_recent(s);
                    if (step_results.size() == 0) add_result(KIND_DONE, 0);
                end
            end
            ACT_CLOSE: begin
                drop_from_queue(s);
                add_result(KIND_DONE, 0);
            end
            ACT_RELEASE_OWNER: begin
                for (i = 0; i < NSLOT && step_results.size() < MaxResults; i++) begin
                    if (sh_valid[i] && sh_owner[i] == own) begin
                        add_result(KIND_RELEASE, i);
                        drop_from_queue(i);
                    end
                end
                if (step_results.size() == 0) add_result(KIND_DONE, 0);
            end
            ACT_FLUSH: begin
                r = sh_count;
                while (r > 0 && step_results.size() < MaxResults) begin
                    r--;
                    victim = slot_at_rank(r);
                    if (victim >= 0 && sh_dirty[victim]) begin
                        add_result(KIND_FLUSH, victim);
                        sh_dirty[victim] = 0;
                    end
                end
                if (step_results.size() == 0) add_result(KIND_DONE, 0);
            end
            default: ;
        endcase
        if (step_results.size() == 0) add_result(KIND_ERROR, 0);
        step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    // Sends one request; valid stays high afterward unless a gap follows.
    task automatic send_request(logic [2:0] act, logic [3:0] s, logic [7:0] own,
                                logic flush, bit typed, logic [2:0] ekind,
                                logic [3:0] eslot);
        int gap;
        t_result res;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= {act, s, own, flush};
        do @(posedge i_clk); while (!req_ch.ready);
        predict_tracker(act, s, own, flush);
        if (typed) begin
            res.kind = ekind;
            res.slot = eslot;
            res.last = 1'b1;
            pending_results.push_back(res);
        end else begin
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        end
        requests_sent++;
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_max_open(logic [4:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_OPEN;
        pwdata <= {27'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sh_max_open = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Often picks the owner of a registered slot, else 3, 200 or a random owner.
    function automatic logic [7:0] some_owner();
        int s;
        s = $urandom_range(0, NSLOT - 1);
        if (sh_valid[s] && $urandom_range(0, 3) != 0) return sh_owner[s];
        case ($urandom_range(0, 2))
            0: return 8'd3;
            1: return 8'd200;
            default: return 8'($urandom);
        endcase
    endfunction

    // Picks a registered slot most of the time.
    function automatic logic [3:0] some_slot();
        int s;
        for (int tries = 0; tries < 4; tries++) begin
            s = $urandom_range(0, NSLOT - 1);
            if (sh_valid[s]) return 4'(s);
        end
        return 4'($urandom_range(0, NSLOT - 1));
    endfunction

    task automatic random_requests(int count);
        int p;
        logic [2:0] act;
        logic [3:0] s;
        logic [7:0] own;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 20) calm = ~calm;
            p = $urandom_range(0, 99);
            s = some_slot();
            own = some_owner();
            if (p < 18) act = ACT_REGISTER;
            else if (p < 30) act = ACT_UNREGISTER;
            else if (p < 65) act = ACT_USE;
            else if (p < 76) act = ACT_CLOSE;
            else if (p < 85) act = ACT_RELEASE_OWNER;
            else if (p < 97) act = ACT_FLUSH;
            else act = 3'($urandom_range(6, 7));
            // A proper unregister uses the slot's own owner.
            if (act == ACT_UNREGISTER && sh_valid[s] && $urandom_range(0, 3) != 0)
                own = sh_owner[s];
            if ($urandom_range(0, 9) == 0) s = 4'($urandom);
            send_request(act, s, own, 1'($urandom), 1'b0, KIND_DONE, 4'd0);
        end
    endtask

    // Result side: checks every accepted result and stalls at random.
    int stall_left;
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result kind=%0d slot=%0d", got.kind, got.slot);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        errors++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("result_slot: expected %0d, got %0d", want.slot, got.slot);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                res_ch.ready <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    t_row directed [] = '{
        '{ACT_REGISTER, 4'd7, 8'd0, 1'b1, 1'b1, KIND_ALLOC, 4'd0},
        '{ACT_REGISTER, 4'd15, 8'd255, 1'b0, 1'b1, KIND_ALLOC, 4'd1},
        '{ACT_UNREGISTER, 4'd1, 8'd0, 1'b0, 1'b1, KIND_ERROR, 4'd0},
        '{ACT_USE, 4'd5, 8'd0, 1'b1, 1'b1, KIND_ERROR, 4'd0},
        '{ACT_BAD_6, 4'd0, 8'd0, 1'b0, 1'b1, KIND_ERROR, 4'd0},
        '{ACT_BAD_7, 4'd15, 8'd255, 1'b1, 1'b1, KIND_ERROR, 4'd0},
        '{ACT_CLOSE, 4'd9, 8'd0, 1'b0, 1'b1, KIND_DONE, 4'd0},
        '{ACT_FLUSH, 4'd0, 8'd0, 1'b0, 1'b1, KIND_DONE, 4'd0},
        '{ACT_USE, 4'd0, 8'd0, 1'b1, 1'b1, KIND_DONE, 4'd0},
        '{ACT_USE, 4'd1, 8'd255, 1'b0, 1'b1, KIND_DONE, 4'd0},
        '{ACT_USE, 4'd0, 8'd0, 1'b0, 1'b0, KIND_DONE, 4'd0},
        '{ACT_USE, 4'd1, 8'd0, 1'b1, 1'b0, KIND_DONE, 4'd0},
        '{ACT_FLUSH, 4'd3, 8'd9, 1'b1, 1'b0, KIND_DONE, 4'd0},
        '{ACT_FLUSH, 4'd0, 8'd0, 1'b0, 1'b1, KIND_DONE, 4'd0},
        '{ACT_RELEASE_OWNER, 4'd0, 8'd255, 1'b0, 1'b0, KIND_DONE, 4'd0},
        '{ACT_RELEASE_OWNER, 4'd0, 8'd77, 1'b0, 1'b1, KIND_DONE, 4'd0},
        '{ACT_CLOSE, 4'd0, 8'd0, 1'b0, 1'b1, KIND_DONE, 4'd0},
        '{ACT_UNREGISTER, 4'd1, 8'd255, 1'b0, 1'b1, KIND_DONE, 4'd0},
        '{ACT_UNREGISTER, 4'd15, 8'd0, 1'b0, 1'b1, KIND_ERROR, 4'd0}
    };

    // Main sequence.
    initial begin
        logic [4:0] settings [6] = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd2, 5'd16};
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        calm = 1'b0;
        sh_max_open = 5'd16;
        sh_count = 0;
        for (int i = 0; i < NSLOT; i++) begin
            sh_valid[i] = 0;
            sh_owner[i] = '0;
            sh_dirty[i] = 0;
            sh_queued[i] = 0;
            sh_rank[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (directed[k])
            send_request(directed[k].action, directed[k].slot, directed[k].owner,
                         directed[k].to_flush, directed[k].typed,
                         directed[k].exp_kind, directed[k].exp_slot);

        // Fill every slot under one owner, overflow, and use them all dirty.
        for (int i = 0; i < NSLOT; i++)
            send_request(ACT_REGISTER, 4'd0, 8'd0, 1'b0, 1'b0, KIND_DONE, 4'd0);
        send_request(ACT_REGISTER, 4'd0, 8'd0, 1'b0, 1'b1, KIND_ERROR, 4'd0);
        for (int i = 0; i < NSLOT; i++)
            send_request(ACT_USE, 4'(i), 8'd0, 1'b1, 1'b0, KIND_DONE, 4'd0);
        send_request(ACT_FLUSH, 4'd0, 8'd0, 1'b0, 1'b0, KIND_DONE, 4'd0);
        send_request(ACT_RELEASE_OWNER, 4'd0, 8'd0, 1'b0, 1'b0, KIND_DONE, 4'd0);

        // Random phases under several queue limits; lowering the limit below
        // the current queue length is part of it.
        foreach (settings[p]) begin
            write_max_open(settings[p]);
            random_requests(40);
        end
        write_max_open(5'($urandom_range(1, 16)));
        random_requests(30);

        drain();
        $display("Sent %0d requests and checked %0d results over seven queue limits,",
                 requests_sent, results_seen);
        $display("including a full row, owner-wide release and eviction cases.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/oflt_pkg.sv
hw/rtl/oflt_if.sv
hw/rtl/oflt_cell.sv
hw/rtl/open_file_lru_tracker.sv
dv/tb_open_file_lru_tracker.sv
